[hdl/ppsa_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register indexes and the controller state type for the
// per-point sweep averager. No dependencies.
package ppsa_pkg;

  localparam int DEF_MAX_POINTS  = 1024;
  localparam int DEF_MAX_DEPTH   = 16;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int INDEX_W    = 10;
  localparam int FILL_W     = 5;
  localparam int ACTIVE_W   = 11;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int NPARTS     = 8;
  localparam int NPARAMS    = 4;

  localparam logic [REG_IDX_W-1:0] REG_AVG_DEPTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MODE       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_PTS  = 2'd2;

  localparam logic MODE_MEAN   = 1'b0;
  localparam logic MODE_MEDIAN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_WALK,
    ST_MED,
    ST_DLOAD,
    ST_DIV,
    ST_DONE
  } ppsa_state_t;

endpackage

[hdl/ppsa_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the sweep averager: one sweep point per item.
// Depends on ppsa_pkg.
interface ppsa_in_if import ppsa_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic        [INDEX_W-1:0]     point_index;
  logic signed [SAMPLE_BITS-1:0] s11_re;
  logic signed [SAMPLE_BITS-1:0] s11_im;
  logic signed [SAMPLE_BITS-1:0] s12_re;
  logic signed [SAMPLE_BITS-1:0] s12_im;
  logic signed [SAMPLE_BITS-1:0] s21_re;
  logic signed [SAMPLE_BITS-1:0] s21_im;
  logic signed [SAMPLE_BITS-1:0] s22_re;
  logic signed [SAMPLE_BITS-1:0] s22_im;

  modport source (output valid, point_index, s11_re, s11_im, s12_re, s12_im,
                  s21_re, s21_im, s22_re, s22_im, input ready);
  modport sink   (input valid, point_index, s11_re, s11_im, s12_re, s12_im,
                  s21_re, s21_im, s22_re, s22_im, output ready);
endinterface

[hdl/ppsa_out_if.sv]
`timescale 1ns / 1ps
// Output channel of the sweep averager: one averaged point per item.
// Depends on ppsa_pkg.
interface ppsa_out_if import ppsa_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic        [INDEX_W-1:0]     out_index;
  logic signed [SAMPLE_BITS-1:0] a11_re;
  logic signed [SAMPLE_BITS-1:0] a11_im;
  logic signed [SAMPLE_BITS-1:0] a12_re;
  logic signed [SAMPLE_BITS-1:0] a12_im;
  logic signed [SAMPLE_BITS-1:0] a21_re;
  logic signed [SAMPLE_BITS-1:0] a21_im;
  logic signed [SAMPLE_BITS-1:0] a22_re;
  logic signed [SAMPLE_BITS-1:0] a22_im;
  logic        [FILL_W-1:0]      history_fill;

  modport source (output valid, out_index, a11_re, a11_im, a12_re, a12_im,
                  a21_re, a21_im, a22_re, a22_im, history_fill, input ready);
  modport sink   (input valid, out_index, a11_re, a11_im, a12_re, a12_im,
                  a21_re, a21_im, a22_re, a22_im, history_fill, output ready);
endinterface

[hdl/per_point_sweep_averager.sv]
`timescale 1ns / 1ps
// Per-point sweep averager: history ring per point, mean or median output.
// Depends on ppsa_pkg, ppsa_in_if and ppsa_out_if.
//
//  channel     dir  handshake      payload
//  sample_in   in   valid/ready    point_index, s11..s22 re/im
//  result_out  out  valid/ready    out_index, a11..a22 re/im, history_fill
//  cfg         in   cfg_we only    cfg_index, cfg_data
//
// A passed-through point skips the history walk. A stored point makes one history
// memory read per stored sample, then takes the median of the sorted cells in
// median mode or runs a bit-serial divide in mean mode.
// Reset and every depth or start-count write run a clearing pass over the
// per-point fill/head memory, during which no item is taken. A finished item
// waits in the output register while the next is taken.
module per_point_sweep_averager import ppsa_pkg::*; #(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ppsa_in_if.sink               sample_in,
  ppsa_out_if.source            result_out
);

  localparam int SB     = SAMPLE_BITS;
  localparam int PW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SLW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int HW     = NPARTS * SB;
  localparam int AW     = SB + FILL_W;
  localparam int MW     = 2 * SB + 1;
  localparam int DCW    = $clog2(AW + 1);
  localparam int MTW    = FILL_W + SLW;
  localparam int HDEPTH = MAX_POINTS * (2 ** SLW);

  function automatic logic [SLW-1:0] wrap_slot(input logic [SLW:0] a);
    if (int'(a) >= MAX_DEPTH) return SLW'(a - (SLW+1)'(MAX_DEPTH));
    return a[SLW-1:0];
  endfunction

  ppsa_state_t state, state_next;

  // Configuration and active count.
  logic [FILL_W-1:0]   avg_depth;
  logic                mode_sel;
  logic [ACTIVE_W-1:0] active_pts;
  logic [FILL_W-1:0]   depth_eff;
  logic                clr_busy;
  logic [PW-1:0]       clr_addr;
  logic                clr_start;

  // Current item.
  logic [INDEX_W-1:0]  cur_idx;
  logic [PW-1:0]       cur_pidx;
  logic [HW-1:0]       cur_smp;
  logic                proc;
  logic [FILL_W-1:0]   cur_fill;
  logic [SLW-1:0]      cur_head;
  logic [FILL_W-1:0]   rd_cnt;
  logic [FILL_W-1:0]   done_cnt;
  logic                v1, v2;
  logic [HW-1:0]       d2;
  logic [2*SB-1:0]     sq [NPARTS];
  logic signed [AW-1:0] acc [NPARTS];

  // Sorting cells, one row per S-parameter.
  logic signed [SB-1:0] srt_re  [NPARAMS][MAX_DEPTH];
  logic signed [SB-1:0] srt_im  [NPARAMS][MAX_DEPTH];
  logic [MW-1:0]        srt_mag [NPARAMS][MAX_DEPTH];
  logic                 srt_vld [MAX_DEPTH];
  logic                 ins_gt  [NPARAMS][MAX_DEPTH];
  logic [MW-1:0]        new_mag [NPARAMS];

  // Divider lanes.
  logic [AW-1:0]       div_num [NPARTS];
  logic [FILL_W-1:0]   div_rem [NPARTS];
  logic                div_neg [NPARTS];
  logic [DCW-1:0]      div_cnt;
  logic [AW-1:0]       q_next  [NPARTS];
  logic [FILL_W-1:0]   r_next  [NPARTS];

  logic [SB-1:0]       res [NPARTS];
  logic [FILL_W-1:0]   res_fill;

  // Memories.
  logic [MTW-1:0]      meta_mem [MAX_POINTS];
  logic [MTW-1:0]      meta_q;
  logic [HW-1:0]       hist_mem [HDEPTH];
  logic [HW-1:0]       hist_q;

  logic                meta_we, hist_we, issue, walk_last, in_acc, out_load;
  logic [PW-1:0]       meta_waddr;
  logic [MTW-1:0]      meta_wdata;
  logic [FILL_W-1:0]   fill0, new_fill;
  logic [SLW-1:0]      head0, new_head, new_slot, rd_slot;
  logic [ACTIVE_W-1:0] active_inc;
  logic [SLW-1:0]      mid_i, lo_i;

  assign in_acc    = sample_in.valid && sample_in.ready;
  assign clr_start = cfg_we && (cfg_index == REG_AVG_DEPTH || cfg_index == REG_START_PTS);

  always_comb begin
    if (avg_depth == '0) depth_eff = FILL_W'(1);
    else if (int'(avg_depth) > MAX_DEPTH) depth_eff = FILL_W'(MAX_DEPTH);
    else depth_eff = avg_depth;
  end

  always_comb begin
    active_inc = active_pts;
    if (ACTIVE_W'(sample_in.point_index) == active_pts && int'(active_pts) < MAX_POINTS) begin
      active_inc = active_pts + ACTIVE_W'(1);
    end
  end

  // Slot bookkeeping for the push.
  always_comb begin
    fill0 = meta_q[MTW-1:SLW];
    head0 = meta_q[SLW-1:0];
    if (fill0 > depth_eff) fill0 = depth_eff;
    if (fill0 < depth_eff) begin
      new_slot = wrap_slot({1'b0, head0} + (SLW+1)'(fill0));
      new_fill = fill0 + FILL_W'(1);
      new_head = head0;
    end else begin
      new_slot = head0;
      new_fill = fill0;
      new_head = wrap_slot({1'b0, head0} + (SLW+1)'(1));
    end
  end

  assign rd_slot   = wrap_slot({1'b0, cur_head} + (SLW+1)'(rd_cnt));
  assign walk_last = v2 && (done_cnt == cur_fill - FILL_W'(1));
  assign mid_i     = SLW'(cur_fill >> 1);
  assign lo_i      = SLW'((cur_fill >> 1) - FILL_W'(1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc) state_next = ST_META;
      ST_META:  state_next = proc ? ST_WALK : ST_DONE;
      ST_WALK:  if (walk_last) state_next = (mode_sel == MODE_MEDIAN) ? ST_MED : ST_DLOAD;
      ST_MED:   state_next = ST_DONE;
      ST_DLOAD: state_next = ST_DIV;
      ST_DIV:   if (div_cnt == DCW'(AW - 1)) state_next = ST_DONE;
      ST_DONE:  if (!result_out.valid || result_out.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    sample_in.ready = (state == ST_IDLE) && !clr_busy;
    issue      = (state == ST_WALK) && (rd_cnt < cur_fill);
    hist_we    = (state == ST_META) && proc;
    meta_we    = clr_busy || hist_we;
    meta_waddr = clr_busy ? clr_addr : cur_pidx;
    meta_wdata = clr_busy ? '0 : {new_fill, new_head};
    out_load   = (state == ST_DONE) && (!result_out.valid || result_out.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Registers, active count and the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_depth  <= FILL_W'(1);
      mode_sel   <= MODE_MEAN;
      active_pts <= '0;
      clr_busy   <= 1'b1;
      clr_addr   <= '0;
    end else begin
      if (clr_busy) begin
        if (clr_addr == PW'(MAX_POINTS - 1)) clr_busy <= 1'b0;
        clr_addr <= clr_addr + PW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_AVG_DEPTH: avg_depth <= cfg_data[FILL_W-1:0];
          REG_MODE:      mode_sel  <= cfg_data[0];
          REG_START_PTS: begin
            if (int'(cfg_data) > MAX_POINTS) active_pts <= ACTIVE_W'(MAX_POINTS);
            else active_pts <= cfg_data;
          end
          default: ;
        endcase
      end
      if (clr_start) begin
        clr_busy <= 1'b1;
        clr_addr <= '0;
      end
      if (in_acc) active_pts <= active_inc;
    end
  end

  // Per-point fill/head memory.
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    meta_q <= meta_mem[PW'(sample_in.point_index)];
  end

  // History memory, one row per point, one word per ring slot.
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[{cur_pidx, new_slot}] <= cur_smp;
    hist_q <= hist_mem[{cur_pidx, rd_slot}];
  end

  // Insertion compare: a new sample goes behind every equal magnitude.
  always_comb begin
    for (int p = 0; p < NPARAMS; p++) begin
      new_mag[p] = MW'(sq[2*p]) + MW'(sq[2*p+1]);
      for (int j = 0; j < MAX_DEPTH; j++) begin
        ins_gt[p][j] = !srt_vld[j] || (srt_mag[p][j] > new_mag[p]);
      end
    end
  end

  // Restoring divide step, one quotient bit per cycle in every lane.
  always_comb begin
    logic [FILL_W:0] rsh;
    for (int k = 0; k < NPARTS; k++) begin
      rsh = {div_rem[k], div_num[k][AW-1]};
      if (rsh >= {1'b0, cur_fill}) begin
        r_next[k] = FILL_W'(rsh - {1'b0, cur_fill});
        q_next[k] = {div_num[k][AW-2:0], 1'b1};
      end else begin
        r_next[k] = rsh[FILL_W-1:0];
        q_next[k] = {div_num[k][AW-2:0], 1'b0};
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    logic signed [SB:0] msum_re, msum_im;
    if (in_acc) begin
      cur_idx  <= sample_in.point_index;
      cur_pidx <= PW'(sample_in.point_index);
      cur_smp  <= {sample_in.s22_im, sample_in.s22_re, sample_in.s21_im, sample_in.s21_re,
                   sample_in.s12_im, sample_in.s12_re, sample_in.s11_im, sample_in.s11_re};
      proc     <= ACTIVE_W'(sample_in.point_index) < active_inc;
    end

    v1 <= issue;
    v2 <= v1;
    if (v1) begin
      d2 <= hist_q;
      for (int k = 0; k < NPARTS; k++) begin
        sq[k] <= $signed(hist_q[k*SB +: SB]) * $signed(hist_q[k*SB +: SB]);
      end
    end

    case (state)
      ST_META: begin
        cur_fill <= new_fill;
        cur_head <= new_head;
        rd_cnt   <= '0;
        done_cnt <= '0;
        for (int k = 0; k < NPARTS; k++) begin
          acc[k] <= '0;
          res[k] <= cur_smp[k*SB +: SB];
        end
        for (int j = 0; j < MAX_DEPTH; j++) srt_vld[j] <= 1'b0;
        res_fill <= proc ? new_fill : '0;
      end
      ST_WALK: begin
        if (issue) rd_cnt <= rd_cnt + FILL_W'(1);
        if (v2) begin
          done_cnt <= done_cnt + FILL_W'(1);
          for (int k = 0; k < NPARTS; k++) begin
            acc[k] <= acc[k] + {{FILL_W{d2[k*SB+SB-1]}}, d2[k*SB +: SB]};
          end
          for (int j = 0; j < MAX_DEPTH; j++) begin
            srt_vld[j] <= srt_vld[j] || (j == 0) || srt_vld[(j > 0) ? j - 1 : 0];
          end
          for (int p = 0; p < NPARAMS; p++) begin
            for (int j = 0; j < MAX_DEPTH; j++) begin
              if (ins_gt[p][j]) begin
                if (j > 0 && ins_gt[p][(j > 0) ? j - 1 : 0]) begin
                  srt_re[p][j]  <= srt_re[p][(j > 0) ? j - 1 : 0];
                  srt_im[p][j]  <= srt_im[p][(j > 0) ? j - 1 : 0];
                  srt_mag[p][j] <= srt_mag[p][(j > 0) ? j - 1 : 0];
                end else begin
                  srt_re[p][j]  <= d2[2*p*SB +: SB];
                  srt_im[p][j]  <= d2[(2*p+1)*SB +: SB];
                  srt_mag[p][j] <= new_mag[p];
                end
              end
            end
          end
        end
      end
      ST_MED: begin
        for (int p = 0; p < NPARAMS; p++) begin
          if (cur_fill[0]) begin
            res[2*p]   <= srt_re[p][mid_i];
            res[2*p+1] <= srt_im[p][mid_i];
          end else begin
            // Floor of the pair mean is an arithmetic shift of the sum.
            msum_re = {srt_re[p][lo_i][SB-1], srt_re[p][lo_i]} +
                      {srt_re[p][mid_i][SB-1], srt_re[p][mid_i]};
            msum_im = {srt_im[p][lo_i][SB-1], srt_im[p][lo_i]} +
                      {srt_im[p][mid_i][SB-1], srt_im[p][mid_i]};
            res[2*p]   <= msum_re[SB:1];
            res[2*p+1] <= msum_im[SB:1];
          end
        end
      end
      ST_DLOAD: begin
        div_cnt <= '0;
        for (int k = 0; k < NPARTS; k++) begin
          div_neg[k] <= acc[k][AW-1];
          div_num[k] <= acc[k][AW-1] ? AW'(-acc[k]) : AW'(acc[k]);
          div_rem[k] <= '0;
        end
      end
      ST_DIV: begin
        div_cnt <= div_cnt + DCW'(1);
        for (int k = 0; k < NPARTS; k++) begin
          div_num[k] <= q_next[k];
          div_rem[k] <= r_next[k];
          if (div_cnt == DCW'(AW - 1)) begin
            res[k] <= div_neg[k] ? SB'(-q_next[k]) : SB'(q_next[k]);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (out_load) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_out.out_index    <= cur_idx;
      result_out.a11_re       <= res[0];
      result_out.a11_im       <= res[1];
      result_out.a12_re       <= res[2];
      result_out.a12_im       <= res[3];
      result_out.a21_re       <= res[4];
      result_out.a21_im       <= res[5];
      result_out.a22_re       <= res[6];
      result_out.a22_im       <= res[7];
      result_out.history_fill <= res_fill;
    end
  end

  a_accept_to_meta: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_META)
    else $error("accepted item did not start a metadata read");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !sample_in.ready)
    else $error("item taken during the clearing pass");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> rd_cnt <= cur_fill)
    else $error("history walk read past the fill");

  a_push_fill: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> new_fill != '0 && new_fill <= depth_eff)
    else $error("push left an impossible fill");

endmodule
